/* rtl/checked_integer_alu_defines.svh */
// Assertion macros for the checked integer ALU.
// Used by the RTL files that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef CHECKED_INTEGER_ALU_DEFINES_SVH
`define CHECKED_INTEGER_ALU_DEFINES_SVH

`define CHKALU_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define CHKALU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/chkalu_pkg.sv */
// Package for the checked integer ALU: operation and error codes, default width.
// Has no dependencies.
`default_nettype none
package chkalu_pkg;
  localparam int WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef logic [2:0] err_t;

  localparam err_t ERR_NONE     = 3'd0;
  localparam err_t ERR_ADD      = 3'd1;
  localparam err_t ERR_SUB      = 3'd2;
  localparam err_t ERR_MUL      = 3'd3;
  localparam err_t ERR_DIV_ZERO = 3'd4;
  localparam err_t ERR_DIV_OVF  = 3'd5;
endpackage
`default_nettype wire

/* rtl/checked_integer_alu.sv */
// Top level of the checked integer ALU: a WIDTH+3 stage pipeline with a one-bit-per-stage
// divider and a split multiplier. Depends on chkalu_pkg and checked_integer_alu_defines.svh.
//
// Each operand pair beat yields one result beat, and a new pair can enter every cycle
// while the output is not stalled; the depth is set by the restoring divider, one quotient
// bit per stage, which every beat passes through whatever the operation. A stalled output
// holds the whole pipeline. The operation register is sampled when a beat enters.
`default_nettype none
`include "checked_integer_alu_defines.svh"
module checked_integer_alu #(
  parameter int WIDTH = chkalu_pkg::WIDTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire  [1:0]              cfg_data,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire  signed [WIDTH-1:0] in_left_operand,
  input  wire  signed [WIDTH-1:0] in_right_operand,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic signed [WIDTH-1:0] out_result_value,
  output logic [2:0]              out_error_code
);
  localparam int H    = (WIDTH + 1) / 2;
  localparam int PW   = 4 * H;
  localparam int LAST = WIDTH + 1;

  typedef struct packed {
    logic               valid;
    chkalu_pkg::op_t    op;
    logic               neg;
    logic [WIDTH-1:0]   res;
    chkalu_pkg::err_t   err;
    logic [WIDTH-1:0]   rem;
    logic [WIDTH-1:0]   quo;
    logic [WIDTH-1:0]   dvs;
  } stg_t;

  chkalu_pkg::op_t op_r;
  stg_t            stg_r   [0:LAST];
  stg_t            stg_nxt [0:LAST];
  logic [2*H-1:0]  pp_r    [0:3];
  logic [2*H-1:0]  pp_nxt  [0:3];
  logic            out_valid_r;
  logic [WIDTH-1:0] out_res_r, out_res_nxt;
  chkalu_pkg::err_t out_err_r;
  logic            adv;

  function automatic stg_t div_step(input stg_t s);
    stg_t         t;
    logic [WIDTH:0] tr;
    logic         bit_q;
    t     = s;
    tr    = {s.rem, s.quo[WIDTH-1]};
    bit_q = (tr >= {1'b0, s.dvs});
    if (bit_q) begin
      tr = tr - {1'b0, s.dvs};
    end
    t.rem = tr[WIDTH-1:0];
    t.quo = {s.quo[WIDTH-2:0], bit_q};
    return t;
  endfunction

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_error_code   = out_err_r;

  always_comb begin
    logic [WIDTH-1:0] a, b, sum, dif, ma, mb, al, bl;
    logic [H-1:0]     ah, bh, a0, b0;
    logic             sa, sb, ovf;
    logic [PW-1:0]    prod, lim;
    a   = stg_r[0].quo;
    b   = stg_r[0].dvs;
    sa  = a[WIDTH-1];
    sb  = b[WIDTH-1];
    sum = a + b;
    dif = a - b;
    ma  = sa ? (~a + 1'b1) : a;
    mb  = sb ? (~b + 1'b1) : b;
    ovf = 1'b0;

    stg_nxt[0]       = stg_r[0];
    stg_nxt[0].valid = in_valid;
    stg_nxt[0].op    = op_r;
    stg_nxt[0].quo   = in_left_operand;
    stg_nxt[0].dvs   = in_right_operand;

    stg_nxt[1]       = stg_r[0];
    stg_nxt[1].neg   = sa ^ sb;
    stg_nxt[1].res   = '0;
    stg_nxt[1].err   = chkalu_pkg::ERR_NONE;
    stg_nxt[1].rem   = '0;
    stg_nxt[1].quo   = ma;
    stg_nxt[1].dvs   = mb;
    case (stg_r[0].op)
      chkalu_pkg::OP_ADD: begin
        ovf = (sa == sb) && (sum[WIDTH-1] != sa);
        stg_nxt[1].err = ovf ? chkalu_pkg::ERR_ADD : chkalu_pkg::ERR_NONE;
        stg_nxt[1].res = ovf ? '0 : sum;
      end
      chkalu_pkg::OP_SUB: begin
        ovf = (sa != sb) && (dif[WIDTH-1] != sa);
        stg_nxt[1].err = ovf ? chkalu_pkg::ERR_SUB : chkalu_pkg::ERR_NONE;
        stg_nxt[1].res = ovf ? '0 : dif;
      end
      chkalu_pkg::OP_DIV: begin
        if (b == '0) begin
          stg_nxt[1].err = chkalu_pkg::ERR_DIV_ZERO;
        end else if (a == {1'b1, {(WIDTH-1){1'b0}}} && b == {WIDTH{1'b1}}) begin
          stg_nxt[1].err = chkalu_pkg::ERR_DIV_OVF;
        end
      end
      default: begin
      end
    endcase

    al = stg_r[1].quo;
    bl = stg_r[1].dvs;
    a0 = al[H-1:0];
    b0 = bl[H-1:0];
    ah = H'(al >> H);
    bh = H'(bl >> H);
    pp_nxt[0] = a0 * b0;
    pp_nxt[1] = a0 * bh;
    pp_nxt[2] = ah * b0;
    pp_nxt[3] = ah * bh;

    prod = PW'(pp_r[0]) + (PW'(pp_r[1]) << H) + (PW'(pp_r[2]) << H)
         + (PW'(pp_r[3]) << (2 * H));
    lim  = (PW'(1) << (WIDTH - 1)) - (stg_r[2].neg ? PW'(0) : PW'(1));

    for (int i = 2; i <= LAST; i++) begin
      stg_nxt[i] = div_step(stg_r[i-1]);
    end
    if (stg_r[2].op == chkalu_pkg::OP_MUL) begin
      if (prod > lim) begin
        stg_nxt[3].err = chkalu_pkg::ERR_MUL;
        stg_nxt[3].res = '0;
      end else begin
        stg_nxt[3].res = stg_r[2].neg ? (~prod[WIDTH-1:0] + 1'b1) : prod[WIDTH-1:0];
      end
    end

    out_res_nxt = stg_r[LAST].res;
    if (stg_r[LAST].op == chkalu_pkg::OP_DIV && stg_r[LAST].err == chkalu_pkg::ERR_NONE) begin
      out_res_nxt = stg_r[LAST].neg ? (~stg_r[LAST].quo + 1'b1) : stg_r[LAST].quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= chkalu_pkg::OP_ADD;
      out_valid_r <= 1'b0;
      for (int i = 0; i <= LAST; i++) begin
        stg_r[i].valid <= 1'b0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        op_r <= chkalu_pkg::op_t'(cfg_data);
      end
      if (adv) begin
        out_valid_r <= stg_r[LAST].valid;
        for (int i = 0; i <= LAST; i++) begin
          stg_r[i].valid <= stg_nxt[i].valid;
        end
      end
    end
    if (adv) begin
      out_res_r <= out_res_nxt;
      out_err_r <= stg_r[LAST].err;
      for (int i = 0; i <= LAST; i++) begin
        stg_r[i].op  <= stg_nxt[i].op;
        stg_r[i].neg <= stg_nxt[i].neg;
        stg_r[i].res <= stg_nxt[i].res;
        stg_r[i].err <= stg_nxt[i].err;
        stg_r[i].rem <= stg_nxt[i].rem;
        stg_r[i].quo <= stg_nxt[i].quo;
        stg_r[i].dvs <= stg_nxt[i].dvs;
      end
      for (int k = 0; k < 4; k++) begin
        pp_r[k] <= pp_nxt[k];
      end
    end
  end

  `CHKALU_ASSERT_IMPLY(a_err_zero, out_valid && out_error_code != chkalu_pkg::ERR_NONE, out_result_value == '0, "result not zero on error")
  `CHKALU_ASSERT_NEVER(a_err_code, out_valid && (out_error_code > chkalu_pkg::ERR_DIV_OVF), "undefined error code")
  `CHKALU_ASSERT_IMPLY(a_stall_src, in_stall, out_valid && out_stall, "input stalled without output backpressure")
endmodule
`default_nettype wire
